/* rtl/core/olt_pkg.sv */
// Package for the ordered list table: sizes, operation and status codes,
// and the control/status structs passed between the controller and the cell chain.
// No dependencies.
`timescale 1ns / 1ps

package olt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_ORDER = 3'd2,
    FN_DELETE    = 3'd3,
    FN_SHOW      = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_SHOW
  } state_t;

  // Chain-wide command
  typedef enum logic [1:0] {
    CH_HOLD,
    CH_INSERT,
    CH_DELETE,
    CH_ROTATE
  } chain_cmd_t;

  // Per-cell load select
  typedef enum logic [2:0] {
    CC_HOLD,
    CC_LEFT,
    CC_RIGHT,
    CC_NEW,
    CC_WRAP
  } cell_cmd_t;

  typedef struct packed {
    chain_cmd_t                 cmd;
    logic [CAPACITY-1:0]        hit;
    logic signed [VALUE_W-1:0]  value;
    logic [CNT_W-1:0]           count;
  } chain_ctl_t;

  typedef struct packed {
    logic [CAPACITY-1:0]        valid;
    logic [CAPACITY-1:0]        lt;
    logic [CAPACITY-1:0]        eq;
    logic signed [VALUE_W-1:0]  head;
  } chain_stat_t;

endpackage

/* rtl/core/olt_cell.sv */
// One list cell: holds a single entry, compares it with the broadcast value
// and loads from its left or right neighbor, the new value or the head.
// Depends on olt_pkg.
`timescale 1ns / 1ps

module olt_cell (
  input  logic                               clk,
  input  olt_pkg::cell_cmd_t                 cmd,
  input  logic signed [olt_pkg::VALUE_W-1:0] left,
  input  logic signed [olt_pkg::VALUE_W-1:0] right,
  input  logic signed [olt_pkg::VALUE_W-1:0] wrap,
  input  logic signed [olt_pkg::VALUE_W-1:0] new_value,
  output logic signed [olt_pkg::VALUE_W-1:0] value,
  output logic                               lt,
  output logic                               eq
);
  import olt_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd)
      CC_LEFT:  value <= left;
      CC_RIGHT: value <= right;
      CC_NEW:   value <= new_value;
      CC_WRAP:  value <= wrap;
      default:  value <= value;
    endcase
  end

  assign lt = (value < new_value);
  assign eq = (value == new_value);

endmodule

/* rtl/core/olt_chain.sv */
// Row of list cells with the per-cell load decode for insert, delete and
// the rotation used to walk the list. Depends on olt_pkg and olt_cell.
`timescale 1ns / 1ps

module olt_chain (
  input  logic                 clk,
  input  olt_pkg::chain_ctl_t  ctl,
  output olt_pkg::chain_stat_t stat
);
  import olt_pkg::*;

  logic signed [VALUE_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]       ahead;
  logic [CAPACITY-1:0]       lt_vec;
  logic [CAPACITY-1:0]       eq_vec;
  logic [CAPACITY-1:0]       valid_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CAPACITY-1:0] LOW_MASK = (CAPACITY'(1) << i) - CAPACITY'(1);
    logic signed [VALUE_W-1:0] left_in;
    logic signed [VALUE_W-1:0] right_in;
    cell_cmd_t                 cell_sel;

    // any hit in a cell nearer the front
    assign ahead[i]     = |(ctl.hit & LOW_MASK);
    assign valid_vec[i] = (CNT_W'(i) < ctl.count);

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner_l
      assign left_in = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign right_in = '0;
    end else begin : g_inner_r
      assign right_in = vals[i+1];
    end

    always_comb begin
      cell_sel = CC_HOLD;
      case (ctl.cmd)
        CH_INSERT: begin
          if (ahead[i]) cell_sel = CC_LEFT;
          else if (ctl.hit[i]) cell_sel = CC_NEW;
        end
        CH_DELETE: begin
          if (ahead[i] || ctl.hit[i]) cell_sel = CC_RIGHT;
        end
        CH_ROTATE: begin
          if (CNT_W'(i + 1) == ctl.count) cell_sel = CC_WRAP;
          else if (CNT_W'(i + 1) < ctl.count) cell_sel = CC_RIGHT;
        end
        default: cell_sel = CC_HOLD;
      endcase
    end

    olt_cell u_cell (
      .clk       (clk),
      .cmd       (cell_sel),
      .left      (left_in),
      .right     (right_in),
      .wrap      (vals[0]),
      .new_value (ctl.value),
      .value     (vals[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i])
    );
  end

  assign stat.valid = valid_vec;
  assign stat.lt    = lt_vec;
  assign stat.eq    = eq_vec;
  assign stat.head  = vals[0];

endmodule

/* rtl/core/ordered_list_table.sv */
// Top level of the ordered list table: transaction control, entry count and
// result register around the cell chain. Depends on olt_pkg and olt_chain.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func and new_value. Output
//   channel (out_valid/out_ready) carries status, entry_value,
//   entry_position, last and entry_count.
//   Insert, delete and no-op items give one result; a result is loaded from
//   the apply state once the output register is free, and the next item is
//   taken after the return to idle. Show walks the list by rotating the cell
//   chain one step per cycle while the output register is free and emits one
//   result per entry (an empty list gives one empty-status result). The
//   rotation returns the chain to its original order when it ends.
//   One item is in work at a time; in_ready is high only while no item is
//   in work, and a finished result may still wait in the output register.
//   A stalled receiver holds the walk or the pending update until the
//   output register frees up.
//   Reset empties the list (count zero) and drops any pending result; entry
//   storage itself is not cleared.
`timescale 1ns / 1ps

module ordered_list_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [olt_pkg::FUNC_W-1:0]         func,
  input  logic signed [olt_pkg::VALUE_W-1:0] new_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [olt_pkg::STAT_W-1:0]         status,
  output logic signed [olt_pkg::VALUE_W-1:0] entry_value,
  output logic [olt_pkg::POS_W-1:0]          entry_position,
  output logic                               last,
  output logic [olt_pkg::COUNT_W-1:0]        entry_count
);
  import olt_pkg::*;

  state_t                    state;
  state_t                    state_next;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [IDX_W-1:0]          step;
  op_t                       op_held;
  status_t                   status_held;
  logic signed [VALUE_W-1:0] value_held;
  logic [CAPACITY-1:0]       hit_held;

  chain_ctl_t                ctl;
  chain_stat_t               stat;

  func_t                     fcode;
  op_t                       op_dec;
  status_t                   status_dec;
  logic [CAPACITY-1:0]       hit_dec;
  logic                      in_fire;
  logic                      out_free;
  logic                      out_load;
  logic                      last_step;
  logic                      full;
  logic                      empty;

  status_t                   res_status;
  logic signed [VALUE_W-1:0] res_value;
  logic [POS_W-1:0]          res_pos;
  logic                      res_last;

  assign fcode     = func_t'(func);
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign last_step = ((CNT_W'(step) + CNT_W'(1)) == count);

  // Decode the transaction against the current cell contents
  always_comb begin
    hit_dec    = '0;
    op_dec     = OP_NONE;
    status_dec = ST_OK;
    unique case (fcode) inside
      FN_INS_FRONT, FN_INS_BACK, FN_INS_ORDER: begin
        if (fcode == FN_INS_FRONT) hit_dec = '1;
        else if (fcode == FN_INS_BACK) hit_dec = ~stat.valid;
        else hit_dec = ~stat.valid | ~stat.lt;
        if (full) status_dec = ST_FULL;
        else op_dec = OP_INSERT;
      end
      FN_DELETE: begin
        hit_dec = stat.valid & stat.eq;
        if (empty) status_dec = ST_EMPTY;
        else if (hit_dec == '0) status_dec = ST_NOT_FOUND;
        else op_dec = OP_DELETE;
      end
      FN_SHOW: begin
        if (empty) status_dec = ST_EMPTY;
      end
      default: begin
        status_dec = ST_OK;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (fcode == FN_SHOW && !empty) state_next = S_SHOW;
          else state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SHOW: begin
        if (out_free && last_step) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Chain command, count update and result fields
  always_comb begin
    ctl.cmd    = CH_HOLD;
    ctl.hit    = hit_held;
    ctl.value  = (state == S_IDLE) ? new_value : value_held;
    ctl.count  = count;
    count_next = count;
    out_load   = 1'b0;
    res_status = status_held;
    res_value  = '0;
    res_pos    = '0;
    res_last   = 1'b1;
    unique case (state)
      S_APPLY: begin
        if (out_free) begin
          out_load = 1'b1;
          if (op_held == OP_INSERT) begin
            ctl.cmd    = CH_INSERT;
            count_next = count + CNT_W'(1);
          end else if (op_held == OP_DELETE) begin
            ctl.cmd    = CH_DELETE;
            count_next = count - CNT_W'(1);
          end
        end
      end
      S_SHOW: begin
        res_status = ST_OK;
        res_value  = stat.head;
        res_pos    = POS_W'(step);
        res_last   = last_step;
        if (out_free) begin
          out_load = 1'b1;
          ctl.cmd  = CH_ROTATE;
        end
      end
      default: begin
        ctl.cmd = CH_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_held     <= op_dec;
      status_held <= status_dec;
      value_held  <= new_value;
      hit_held    <= hit_dec;
    end
    if (state == S_IDLE) step <= '0;
    else if (state == S_SHOW && out_free) step <= step + IDX_W'(1);
    if (out_load) begin
      status         <= res_status;
      entry_value    <= res_value;
      entry_position <= res_pos;
      last           <= res_last;
      entry_count    <= COUNT_W'(count_next);
    end
  end

  olt_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .stat (stat)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_show_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) |-> (count != '0))
    else $error("list walk with no entries");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("second transaction taken while one is in work");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> full)
    else $error("full status reported on a list with free room");

endmodule

/* tb/sv/ordered_list_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_table: a directed table of list operations,
// then random traffic under several idle/stall mixes, scored against an in-bench list model.
// Depends on olt_pkg and the ordered_list_table RTL.

module ordered_list_table_tb;
  import olt_pkg::*;

  // func codes with no operation behind them
  localparam logic [FUNC_W-1:0] FN_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

  localparam int SHOW_MAX     = 1 << POS_W;
  localparam int PHASE_ITEMS  = 21;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    status_t                   st;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    logic                      last;
    logic [COUNT_W-1:0]        count;
  } list_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]         f;
    logic signed [VALUE_W-1:0] v;
    logic [4:0]                reps;
    logic                      typed;
    status_t                   st;
    logic [COUNT_W-1:0]        cnt;
  } op_row_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func      = '0;
  logic signed [VALUE_W-1:0] new_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STAT_W-1:0]         status;
  logic signed [VALUE_W-1:0] entry_value;
  logic [POS_W-1:0]          entry_position;
  logic                      last;
  logic [COUNT_W-1:0]        entry_count;

  logic signed [VALUE_W-1:0] list_q[$];
  list_result_t              staged_q[$];
  list_result_t              pending_q[$];
  op_row_t                   op_table[$];
  list_result_t              head_r;

  int errors         = 0;
  int checked        = 0;
  int sent           = 0;
  int directed       = 0;
  int shows          = 0;
  int full_rejects   = 0;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  ordered_list_table dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               pending_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Score every result transaction against the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result st=%0d val=%0d pos=%0d last=%0b cnt=%0d", $time,
                 status, entry_value, entry_position, last, entry_count);
      end else begin
        head_r = pending_q.pop_front();
        if (status !== head_r.st || entry_value !== head_r.value ||
            entry_position !== head_r.pos || last !== head_r.last ||
            entry_count !== head_r.count) begin
          errors++;
          $display("%0t: mismatch exp st=%0d val=%0d pos=%0d last=%0b cnt=%0d", $time,
                   head_r.st, head_r.value, head_r.pos, head_r.last, head_r.count);
          $display("%0t:          got st=%0d val=%0d pos=%0d last=%0b cnt=%0d", $time,
                   status, entry_value, entry_position, last, entry_count);
        end
        checked++;
      end
    end
  end

  function automatic list_result_t make_result(input status_t st,
                                               input logic signed [VALUE_W-1:0] val,
                                               input int pos, input logic lst);
    list_result_t r;
    r.st    = st;
    r.value = val;
    r.pos   = POS_W'(pos);
    r.last  = lst;
    r.count = COUNT_W'(list_q.size());
    return r;
  endfunction

  // Apply one operation to the list model and stage the results it causes
  function automatic void apply_list_op(input logic [FUNC_W-1:0] f,
                                        input logic signed [VALUE_W-1:0] v);
    int idx;
    int n;
    staged_q.delete();
    case (f)
      FN_INS_FRONT, FN_INS_BACK, FN_INS_ORDER: begin
        if (list_q.size() >= CAPACITY) begin
          full_rejects++;
          staged_q.push_back(make_result(ST_FULL, '0, 0, 1'b1));
        end else begin
          if (f == FN_INS_FRONT) begin
            list_q.push_front(v);
          end else if (f == FN_INS_BACK) begin
            list_q.push_back(v);
          end else begin
            idx = 0;
            while (idx < list_q.size() && list_q[idx] < v) idx++;
            list_q.insert(idx, v);
          end
          staged_q.push_back(make_result(ST_OK, '0, 0, 1'b1));
        end
      end
      FN_DELETE: begin
        if (list_q.size() == 0) begin
          staged_q.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          idx = 0;
          while (idx < list_q.size() && list_q[idx] != v) idx++;
          if (idx == list_q.size()) begin
            staged_q.push_back(make_result(ST_NOT_FOUND, '0, 0, 1'b1));
          end else begin
            list_q.delete(idx);
            staged_q.push_back(make_result(ST_OK, '0, 0, 1'b1));
          end
        end
      end
      FN_SHOW: begin
        shows++;
        if (list_q.size() == 0) begin
          staged_q.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          n = (list_q.size() < SHOW_MAX) ? list_q.size() : SHOW_MAX;
          for (int i = 0; i < n; i++)
            staged_q.push_back(make_result(ST_OK, list_q[i], i, i + 1 == n));
        end
      end
      default: begin
        staged_q.push_back(make_result(ST_OK, '0, 0, 1'b1));
      end
    endcase
  endfunction

  // Drive one input transaction; typed rows replace the model's single result
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic signed [VALUE_W-1:0] v,
                           input logic typed, input status_t st,
                           input logic [COUNT_W-1:0] cnt);
    list_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    func      <= f;
    new_value <= v;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_list_op(f, v);
    if (typed) begin
      r.st    = st;
      r.value = '0;
      r.pos   = '0;
      r.last  = 1'b1;
      r.count = cnt;
      staged_q.delete();
      staged_q.push_back(r);
    end
    foreach (staged_q[i]) pending_q.push_back(staged_q[i]);
    sent++;
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] f, input logic signed [VALUE_W-1:0] v,
                         input int reps, input logic typed, input status_t st,
                         input int cnt);
    op_row_t row;
    row.f     = f;
    row.v     = v;
    row.reps  = 5'(reps);
    row.typed = typed;
    row.st    = st;
    row.cnt   = COUNT_W'(cnt);
    op_table.push_back(row);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return $urandom();
    if (pick < 8) return $signed($urandom_range(16)) - 8;
    if (pick == 8) return 32'sh7fffffff;
    return 32'sh80000000;
  endfunction

  // grow biases toward inserts so the list fills; otherwise toward deletes
  task automatic send_random(input logic grow);
    int pick;
    int ins_share;
    logic [FUNC_W-1:0] f;
    logic signed [VALUE_W-1:0] v;
    pick      = $urandom_range(99);
    ins_share = grow ? 50 : 28;
    v         = random_value();
    if (pick < ins_share / 3) begin
      f = FN_INS_FRONT;
    end else if (pick < 2 * ins_share / 3) begin
      f = FN_INS_BACK;
    end else if (pick < ins_share) begin
      f = FN_INS_ORDER;
    end else if (pick < 78) begin
      f = FN_DELETE;
      // mostly hit a stored value so deletes actually remove something
      if (list_q.size() > 0 && $urandom_range(9) < 7)
        v = list_q[$urandom_range(list_q.size() - 1)];
    end else if (pick < 94) begin
      f = FN_SHOW;
    end else begin
      f = FUNC_W'($urandom_range(FN_RSVD7, FN_RSVD5));
    end
    send_item(f, v, 1'b0, ST_OK, '0);
  endtask

  initial begin
    // empty list, single-entry list, signed extremes, duplicates, full list
    add_row(FN_SHOW,      32'sd0,         1, 1'b1, ST_EMPTY,     0);
    add_row(FN_DELETE,    32'sd7,         1, 1'b1, ST_EMPTY,     0);
    add_row(FN_INS_BACK,  32'sd5,         1, 1'b1, ST_OK,        1);
    add_row(FN_SHOW,      32'sd0,         1, 1'b0, ST_OK,        0);
    add_row(FN_DELETE,    32'sd5,         1, 1'b1, ST_OK,        0);
    add_row(FN_SHOW,      -32'sd1,        1, 1'b1, ST_EMPTY,     0);
    add_row(FN_INS_ORDER, 32'sh80000000,  1, 1'b1, ST_OK,        1);
    add_row(FN_INS_ORDER, 32'sh7fffffff,  1, 1'b1, ST_OK,        2);
    add_row(FN_INS_ORDER, 32'sd0,         1, 1'b1, ST_OK,        3);
    add_row(FN_INS_ORDER, -32'sd1,        1, 1'b1, ST_OK,        4);
    add_row(FN_INS_ORDER, 32'sd0,         1, 1'b1, ST_OK,        5);
    add_row(FN_INS_FRONT, 32'sh7fffffff,  1, 1'b1, ST_OK,        6);
    add_row(FN_DELETE,    32'sd12345,     1, 1'b1, ST_NOT_FOUND, 6);
    add_row(FN_DELETE,    32'sd0,         1, 1'b1, ST_OK,        5);
    add_row(FN_RSVD5,     -32'sd1,        1, 1'b1, ST_OK,        5);
    add_row(FN_RSVD6,     32'sd3,         1, 1'b1, ST_OK,        5);
    add_row(FN_RSVD7,     32'sh55555555,  1, 1'b1, ST_OK,        5);
    add_row(FN_SHOW,      32'sd0,         1, 1'b0, ST_OK,        0);
    add_row(FN_INS_BACK,  32'sh55555555, 11, 1'b0, ST_OK,        0);
    add_row(FN_INS_FRONT, 32'sd1,         1, 1'b1, ST_FULL,      16);
    add_row(FN_INS_BACK,  32'sd2,         1, 1'b1, ST_FULL,      16);
    add_row(FN_INS_ORDER, 32'sd3,         1, 1'b1, ST_FULL,      16);
    add_row(FN_SHOW,      32'sd0,         1, 1'b0, ST_OK,        0);
    add_row(FN_DELETE,    32'sh80000000,  1, 1'b1, ST_OK,        15);
    add_row(FN_INS_ORDER, 32'shaaaaaaaa,  1, 1'b0, ST_OK,        0);
    add_row(FN_SHOW,      32'sd0,         1, 1'b0, ST_OK,        0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (op_table[r]) begin
      for (int k = 0; k < op_table[r].reps; k++) begin
        send_item(op_table[r].f, op_table[r].v + k, op_table[r].typed, op_table[r].st,
                  op_table[r].cnt);
        directed++;
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_random((phase % 2) == 0);
    end

    @(negedge clk);
    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (pending_q.size() != 0) @(posedge clk);
    // hold a little longer to catch any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d from the directed table), scored %0d results;", sent,
             directed, checked);
    $display("%0d show walks and %0d inserts rejected on a full list.", shows, full_rejects);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
